// ----- src/i2c_mrr_pkg.sv -----
// i2c_mrr_pkg: types and constants shared by the I2C register-read master.
// Holds the request/response payload structs, configuration and FSM state types.
// No dependencies.
`default_nettype none

package i2c_mrr_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_STRETCH_LIMIT     = 2'd0;
   localparam logic [1:0] CSR_ADDRESS_LIMIT     = 2'd1;
   localparam logic [1:0] CSR_TRANSACTION_LIMIT = 2'd2;

   localparam logic [15:0] STRETCH_LIMIT_RESET     = 16'd1000;
   localparam logic [7:0]  ADDRESS_LIMIT_RESET     = 8'd10;
   localparam logic [7:0]  TRANSACTION_LIMIT_RESET = 8'd20;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // Request opcodes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_START = 3'd1,
      PH_SEND  = 3'd2,
      PH_GAP   = 3'd3,
      PH_STOP  = 3'd4,
      PH_RECV  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      LEG_WRITE = 2'd0,
      LEG_REG   = 2'd1,
      LEG_READ  = 2'd2
   } leg_type;

   typedef enum logic [1:0] {
      LINE_NONE = 2'd0,
      LINE_SDA  = 2'd1,
      LINE_SCL  = 2'd2
   } line_type;

   typedef struct packed {
      logic        op;
      logic        sda_in;
      logic        scl_in;
      logic [6:0]  slave_address;
      logic [7:0]  register_address;
      logic [15:0] read_length;
   } req_type;

   typedef struct packed {
      logic       scl_drive;
      logic       sda_drive;
      logic       data_valid;
      logic [7:0] read_data;
      logic       data_last;
      logic       busy_res;
      logic       done_res;
      logic       success;
   } rsp_type;

   typedef struct packed {
      logic [15:0] stretch_limit;
      logic [7:0]  address_retry_limit;
      logic [7:0]  transaction_retry_limit;
   } cfg_type;

   // Sequencer state apart from the byte counter, whose width is a parameter
   typedef struct packed {
      phase_type   phase;
      logic [2:0]  sub_step;
      logic [3:0]  bit_count;
      logic [7:0]  shift_byte;
      logic [15:0] wait_count;
      logic [7:0]  address_tries;
      logic [7:0]  transaction_tries;
      logic [6:0]  target_address;
      logic [7:0]  target_register;
      logic        scl_out;
      logic        sda_out;
      line_type    wait_line;
      leg_type     leg;
      logic        stop_is_final;
      logic        final_ok;
   } st_type;

   localparam st_type ST_RESET = '{
      phase:             PH_IDLE,
      sub_step:          3'd0,
      bit_count:         4'd0,
      shift_byte:        8'd0,
      wait_count:        16'd0,
      address_tries:     8'd0,
      transaction_tries: 8'd0,
      target_address:    7'd0,
      target_register:   8'd0,
      scl_out:           1'b1,
      sda_out:           1'b1,
      wait_line:         LINE_NONE,
      leg:               LEG_WRITE,
      stop_is_final:     1'b0,
      final_ok:          1'b0
   };

endpackage

`default_nettype wire

// ----- src/i2c_master_register_read.sv -----
// i2c_master_register_read: top level of the I2C combined register-read master.
// Instantiates i2c_mrr_csr and i2c_mrr_step; depends on i2c_mrr_pkg.
//
// Usage
//   req_*  : one request per bit-delay period. op = tick carries the sampled
//            SDA/SCL levels; op = start loads address, sub-address and byte
//            count (dropped unless the block is idle).
//   rsp_*  : exactly one response per request, in order: the line drives for
//            the next period, a received byte with its last flag, busy, and a
//            done/success pair after the closing STOP.
//   csr_*  : plain write port (stretch limit, address and transaction retry
//            limits); write only while no request is in flight.
// Path: a request passes from the input register through one step of the
//   sequencer into the response register.
// Throughput: one request per cycle; the sequencer state feeds back over a
//   single step, so the input register drains each cycle the response
//   register is free or being taken.
// Reset: synchronous, active high; sequencer idle with both lines released,
//   limits back to 1000 / 10 / 20, both registers empty.
// Stall: when rsp_ready is low the response holds, one more request waits
//   in the input register, and req_ready drops until the response is taken.
`default_nettype none

module i2c_master_register_read #(
   parameter int LENGTH_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire i2c_mrr_pkg::req_type  req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output i2c_mrr_pkg::rsp_type       rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [1:0]            csr_index,
   input  wire logic [15:0]           csr_wdata
);
   import i2c_mrr_pkg::*;

   cfg_type cfg;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   // sequencer state
   st_type                  st_ff, st_in;
   logic [LENGTH_WIDTH-1:0] bytes_left_ff, bytes_left_in;

   rsp_type step_rsp;
   logic    advance;
   logic    take_req;

   i2c_mrr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2c_mrr_step #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_step (
      .st              (st_ff),
      .bytes_left      (bytes_left_ff),
      .req             (in_data_ff),
      .cfg             (cfg),
      .st_next         (st_in),
      .bytes_left_next (bytes_left_in),
      .rsp             (step_rsp)
   );

   // the held request steps the sequencer once the response slot is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take_req  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take_req) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         st_ff         <= ST_RESET;
         bytes_left_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            st_ff         <= st_in;
            bytes_left_ff <= bytes_left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- src/i2c_mrr_csr.sv -----
// i2c_mrr_csr: configuration registers of the I2C register-read master.
// Depends on i2c_mrr_pkg.
`default_nettype none

module i2c_mrr_csr (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [1:0]           csr_index,
   input  wire logic [15:0]          csr_wdata,
   output i2c_mrr_pkg::cfg_type      cfg
);
   import i2c_mrr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_STRETCH_LIMIT:     cfg_in.stretch_limit = csr_wdata;
            CSR_ADDRESS_LIMIT:     cfg_in.address_retry_limit = csr_wdata[7:0];
            CSR_TRANSACTION_LIMIT: cfg_in.transaction_retry_limit = csr_wdata[7:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stretch_limit           <= STRETCH_LIMIT_RESET;
         cfg_ff.address_retry_limit     <= ADDRESS_LIMIT_RESET;
         cfg_ff.transaction_retry_limit <= TRANSACTION_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- src/i2c_mrr_step.sv -----
// i2c_mrr_step: one bit-period step of the I2C register-read sequencer.
// Purely combinational: current state and request in, next state and response out.
// Depends on i2c_mrr_pkg.
`default_nettype none

module i2c_mrr_step #(
   parameter int LENGTH_WIDTH = 16
) (
   input  wire i2c_mrr_pkg::st_type   st,
   input  wire logic [LENGTH_WIDTH-1:0] bytes_left,
   input  wire i2c_mrr_pkg::req_type  req,
   input  wire i2c_mrr_pkg::cfg_type  cfg,
   output i2c_mrr_pkg::st_type        st_next,
   output logic [LENGTH_WIDTH-1:0]    bytes_left_next,
   output i2c_mrr_pkg::rsp_type       rsp
);
   import i2c_mrr_pkg::*;

   function automatic st_type go(st_type s, phase_type ph);
      st_type r;
      r          = s;
      r.phase    = ph;
      r.sub_step = 3'd0;
      return r;
   endfunction

   function automatic st_type final_stop(st_type s, logic ok);
      st_type r;
      r               = s;
      r.stop_is_final = 1'b1;
      r.final_ok      = ok;
      return go(r, PH_STOP);
   endfunction

   function automatic st_type arm_wait(st_type s, line_type line);
      st_type r;
      r            = s;
      r.wait_line  = line;
      r.wait_count = 16'd0;
      return r;
   endfunction

   function automatic st_type fail_attempt(st_type s, cfg_type c);
      st_type r;
      r                   = s;
      r.transaction_tries = s.transaction_tries + 8'd1;
      if (r.transaction_tries >= c.transaction_retry_limit || c.address_retry_limit == 8'd0) begin
         r = final_stop(r, 1'b0);
      end else begin
         r.leg           = LEG_WRITE;
         r.address_tries = 8'd0;
         r               = go(r, PH_START);
      end
      return r;
   endfunction

   function automatic st_type begin_access(st_type s, cfg_type c, leg_type which);
      st_type r;
      r = s;
      if (c.address_retry_limit == 8'd0) begin
         r = fail_attempt(r, c);
      end else begin
         r.leg           = which;
         r.address_tries = 8'd0;
         r               = go(r, PH_START);
      end
      return r;
   endfunction

   function automatic st_type next_address_try(st_type s, cfg_type c);
      st_type r;
      r               = s;
      r.address_tries = s.address_tries + 8'd1;
      if (r.address_tries >= c.address_retry_limit) begin
         r = fail_attempt(r, c);
      end else begin
         r = go(r, PH_START);
      end
      return r;
   endfunction

   function automatic st_type begin_send(st_type s, logic [7:0] value);
      st_type r;
      r            = s;
      r.shift_byte = value;
      r.bit_count  = 4'd0;
      return go(r, PH_SEND);
   endfunction

   function automatic st_type after_send(st_type s, cfg_type c, logic acked, logic none_left);
      st_type r;
      r = s;
      if (s.leg == LEG_REG) begin
         r = acked ? begin_access(r, c, LEG_READ) : fail_attempt(r, c);
      end else if (!acked) begin
         r = go(r, PH_GAP);
      end else if (s.leg == LEG_WRITE) begin
         r.leg = LEG_REG;
         r     = begin_send(r, s.target_register);
      end else if (none_left) begin
         r = final_stop(r, 1'b1);
      end else begin
         r.bit_count  = 4'd0;
         r.shift_byte = 8'd0;
         r            = go(r, PH_RECV);
      end
      return r;
   endfunction

   st_type n;
   logic [LENGTH_WIDTH-1:0] bl_n;
   logic run;
   logic level;
   logic dv;
   logic last;
   logic done;
   logic ok;
   logic [7:0] data;

   always_comb begin
      n     = st;
      bl_n  = bytes_left;
      run   = 1'b1;
      dv    = 1'b0;
      last  = 1'b0;
      done  = 1'b0;
      ok    = 1'b0;
      data  = 8'd0;
      level = 1'b0;

      if (req.op == OP_START) begin
         // a command while busy is dropped without a tick
         run = 1'b0;
         if (st.phase == PH_IDLE) begin
            n.target_address    = req.slave_address;
            n.target_register   = req.register_address;
            bl_n                = req.read_length[LENGTH_WIDTH-1:0];
            n.transaction_tries = 8'd0;
            n.wait_line         = LINE_NONE;
            n.scl_out           = 1'b1;
            n.sda_out           = 1'b1;
            if (cfg.transaction_retry_limit == 8'd0) begin
               n = final_stop(n, 1'b0);
            end else begin
               n = begin_access(n, cfg, LEG_WRITE);
            end
         end
      end else if (st.phase == PH_IDLE) begin
         run       = 1'b0;
         n.scl_out = 1'b1;
         n.sda_out = 1'b1;
      end

      // clock stretching / released-line poll
      if (run && n.wait_line != LINE_NONE) begin
         level = (n.wait_line == LINE_SDA) ? req.sda_in : req.scl_in;
         if (!level && n.wait_count < cfg.stretch_limit) begin
            n.wait_count = n.wait_count + 16'd1;
            run          = 1'b0;
         end else begin
            n.wait_line = LINE_NONE;
         end
      end

      if (run) begin
         case (n.phase)
            PH_START: begin
               case (n.sub_step)
                  3'd0: begin
                     n.sda_out  = 1'b1;
                     n          = arm_wait(n, LINE_SDA);
                     n.sub_step = 3'd1;
                  end
                  3'd1: begin
                     n.scl_out  = 1'b1;
                     n          = arm_wait(n, LINE_SCL);
                     n.sub_step = 3'd2;
                  end
                  3'd2: begin
                     if (!req.sda_in || !req.scl_in) begin
                        n = next_address_try(n, cfg);
                     end else begin
                        n.sda_out  = 1'b0;
                        n.sub_step = 3'd3;
                     end
                  end
                  default: begin
                     n.scl_out = 1'b0;
                     n = begin_send(n, {n.target_address, (n.leg == LEG_READ)});
                  end
               endcase
            end
            PH_SEND: begin
               case (n.sub_step)
                  3'd0: begin
                     n.scl_out  = 1'b0;
                     n.sub_step = 3'd1;
                  end
                  3'd1: begin
                     if (n.shift_byte[3'd7 - n.bit_count[2:0]]) begin
                        n.sda_out = 1'b1;
                        n         = arm_wait(n, LINE_SDA);
                     end else begin
                        n.sda_out = 1'b0;
                     end
                     n.sub_step = 3'd2;
                  end
                  3'd2: begin
                     n.scl_out  = 1'b1;
                     n          = arm_wait(n, LINE_SCL);
                     n.sub_step = 3'd3;
                  end
                  3'd3: begin
                     n.scl_out   = 1'b0;
                     n.bit_count = n.bit_count + 4'd1;
                     n.sub_step  = (n.bit_count >= BITS_PER_BYTE) ? 3'd4 : 3'd1;
                  end
                  3'd4: begin
                     n.sda_out  = 1'b1;
                     n.sub_step = 3'd5;
                  end
                  3'd5: begin
                     n.scl_out  = 1'b1;
                     n          = arm_wait(n, LINE_SCL);
                     n.sub_step = 3'd6;
                  end
                  default: begin
                     n.scl_out = 1'b0;
                     n = after_send(n, cfg, !req.sda_in, bl_n == '0);
                  end
               endcase
            end
            PH_GAP: begin
               if (n.sub_step == 3'd0) begin
                  n.sub_step = 3'd1;
               end else begin
                  n.stop_is_final = 1'b0;
                  n = go(n, PH_STOP);
               end
            end
            PH_STOP: begin
               case (n.sub_step)
                  3'd0: begin
                     n.scl_out  = 1'b0;
                     n.sub_step = 3'd1;
                  end
                  3'd1: begin
                     n.sda_out  = 1'b0;
                     n.sub_step = 3'd2;
                  end
                  3'd2: begin
                     n.scl_out  = 1'b1;
                     n          = arm_wait(n, LINE_SCL);
                     n.sub_step = 3'd3;
                  end
                  3'd3: begin
                     n.sda_out  = 1'b1;
                     n          = arm_wait(n, LINE_SDA);
                     n.sub_step = 3'd4;
                  end
                  default: begin
                     if (n.stop_is_final) begin
                        done = 1'b1;
                        ok   = n.final_ok;
                        n    = go(n, PH_IDLE);
                     end else begin
                        n = next_address_try(n, cfg);
                     end
                  end
               endcase
            end
            PH_RECV: begin
               case (n.sub_step)
                  3'd0: begin
                     n.sda_out  = 1'b1;
                     n.scl_out  = 1'b1;
                     n          = arm_wait(n, LINE_SCL);
                     n.sub_step = 3'd1;
                  end
                  3'd1: begin
                     n.shift_byte = {n.shift_byte[6:0], req.sda_in};
                     n.scl_out    = 1'b0;
                     n.bit_count  = n.bit_count + 4'd1;
                     if (n.bit_count >= BITS_PER_BYTE) begin
                        bl_n       = bl_n - LENGTH_WIDTH'(1);
                        dv         = 1'b1;
                        data       = n.shift_byte;
                        last       = (bl_n == '0);
                        n.sub_step = 3'd2;
                     end else begin
                        n.sub_step = 3'd0;
                     end
                  end
                  3'd2: begin
                     // ACK while bytes remain, NACK on the last one
                     if (bl_n != '0) begin
                        n.sda_out = 1'b0;
                     end else begin
                        n.sda_out = 1'b1;
                        n         = arm_wait(n, LINE_SDA);
                     end
                     n.sub_step = 3'd3;
                  end
                  3'd3: begin
                     n.scl_out  = 1'b1;
                     n          = arm_wait(n, LINE_SCL);
                     n.sub_step = 3'd4;
                  end
                  default: begin
                     n.scl_out = 1'b0;
                     if (bl_n == '0) begin
                        n = final_stop(n, 1'b1);
                     end else begin
                        n.bit_count  = 4'd0;
                        n.shift_byte = 8'd0;
                        n.sub_step   = 3'd0;
                     end
                  end
               endcase
            end
            default: begin
               n         = go(n, PH_IDLE);
               n.scl_out = 1'b1;
               n.sda_out = 1'b1;
            end
         endcase
      end
   end

   assign st_next         = n;
   assign bytes_left_next = bl_n;

   always_comb begin
      rsp.scl_drive  = n.scl_out;
      rsp.sda_drive  = n.sda_out;
      rsp.data_valid = dv;
      rsp.read_data  = data;
      rsp.data_last  = last;
      rsp.busy_res   = (n.phase != PH_IDLE);
      rsp.done_res   = done;
      rsp.success    = ok;
   end

endmodule

`default_nettype wire

// ----- src/i2c_mrr_checker.sv -----
// i2c_mrr_checker: port-level assertions for the I2C register-read master,
// bound to the top level. Depends on i2c_mrr_pkg and i2c_master_register_read.
`default_nettype none

module i2c_mrr_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire i2c_mrr_pkg::rsp_type rsp_data
);
   import i2c_mrr_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // done is reported only once the sequencer is back to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
      else $error("done reported while busy");

   // success only accompanies done
   a_success_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.success |-> rsp_data.done_res)
      else $error("success without done");

   // a byte is presented mid-transaction, and last only with a byte
   a_byte_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.data_valid |-> rsp_data.busy_res && !rsp_data.done_res)
      else $error("byte presented outside a transaction");

   a_last_with_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.data_last |-> rsp_data.data_valid)
      else $error("last flag without a byte");

endmodule

bind i2c_master_register_read i2c_mrr_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
